/* sv/sdft_pkg.sv */
// Shared types and constants for the sliding DFT dominant-bin block.
// Used by sdft_mac and sliding_dft_dominant_bin_unit; no dependencies.
package sdft_pkg;

  localparam int SAMPLE_W     = 16;  // input sample, signed
  localparam int STATE_W      = 40;  // bin state, Q24.16 signed
  localparam int FRAC_W       = 16;  // fraction bits of state and twiddles
  localparam int INT_W        = STATE_W - FRAC_W;  // integer part of a bin
  localparam int PR_W         = STATE_W + 1;       // real part minus oldest sample
  localparam int TW_W         = 18;  // Q1.16 twiddle, signed
  localparam int MUL_W        = 25;  // shared multiplier operand, signed
  localparam int PROD_W       = 2 * MUL_W;
  localparam int ACC_W        = 60;  // product accumulator
  localparam int SPLIT_W      = 24;  // low slice of a split operand
  localparam int POW_W        = 48;  // power result
  localparam int BIN_W        = 8;   // reported bin index
  localparam int DEFAULT_BINS = 256;

  typedef enum logic [3:0] {
    MAC_RE_LO_C  = 4'd0,
    MAC_RE_HI_C  = 4'd1,
    MAC_RE_LO_S  = 4'd2,
    MAC_RE_HI_S  = 4'd3,
    MAC_IM_LO_S  = 4'd4,
    MAC_IM_HI_S  = 4'd5,
    MAC_IM_LO_C  = 4'd6,
    MAC_IM_HI_C  = 4'd7,
    MAC_PWR_RE   = 4'd8,
    MAC_PWR_IM   = 4'd9
  } mac_op_e;

  typedef struct packed {
    logic    init;   // load accumulators with rounding offset and sample
    logic    issue;  // start a product this cycle
    mac_op_e op;
  } mac_ctrl_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PREP,
    ST_MUL,
    ST_ACC,
    ST_RND,
    ST_PWR,
    ST_SUM,
    ST_CMP,
    ST_DONE
  } state_e;

endpackage

/* sv/sdft_twiddle_rom.sv */
// Twiddle ROM: cos/sin(2*pi*k/BINS) in Q1.16, built at elaboration.
// Octant reduction plus a Q30 Taylor series; registered read. No package use.
module sdft_twiddle_rom #(
  parameter int BINS = 256
) (
  input  logic                      clk_i,
  input  logic [$clog2(BINS)-1:0]   addr_i,
  output logic signed [17:0]        cos_o,
  output logic signed [17:0]        sin_o
);

  localparam logic [63:0] N       = 64'(BINS);
  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] PI_4    = 64'd843314857;

  typedef logic [35:0] twid_tab_t [BINS];

  // Q30 -> Q16, round half away from zero
  function automatic logic signed [17:0] to_q16(input logic signed [63:0] v);
    logic signed [63:0] m;
    if (v >= 0) begin
      m = (v + 64'sd8192) >>> 14;
    end else begin
      m = -((-v + 64'sd8192) >>> 14);
    end
    return 18'(m);
  endfunction

  function automatic logic [35:0] twiddle(input int k);
    logic [63:0]        e, oct, r, a, x, x2, ts, tc;
    logic signed [63:0] s, c, rc, rs;
    e   = 64'd8 * 64'(k);
    oct = (e / N) & 64'd7;
    r   = e % N;
    a   = oct[0] ? N - r : r;
    x   = (a * PI_4 + N / 2) / N;
    x2  = (x * x) >> 30;
    ts  = x;
    tc  = Q30_ONE;
    s   = $signed(ts);
    c   = $signed(tc);
    ts = ((ts * x2) >> 30) / 6;   tc = ((tc * x2) >> 30) / 2;
    s  = s - $signed(ts);         c  = c - $signed(tc);
    ts = ((ts * x2) >> 30) / 20;  tc = ((tc * x2) >> 30) / 12;
    s  = s + $signed(ts);         c  = c + $signed(tc);
    ts = ((ts * x2) >> 30) / 42;  tc = ((tc * x2) >> 30) / 30;
    s  = s - $signed(ts);         c  = c - $signed(tc);
    ts = ((ts * x2) >> 30) / 72;  tc = ((tc * x2) >> 30) / 56;
    s  = s + $signed(ts);         c  = c + $signed(tc);
    ts = ((ts * x2) >> 30) / 110; tc = ((tc * x2) >> 30) / 90;
    s  = s - $signed(ts);         c  = c - $signed(tc);
    ts = ((ts * x2) >> 30) / 156; tc = ((tc * x2) >> 30) / 132;
    s  = s + $signed(ts);         c  = c + $signed(tc);
    ts = ((ts * x2) >> 30) / 210; tc = ((tc * x2) >> 30) / 182;
    s  = s - $signed(ts);         c  = c - $signed(tc);
    ts = ((ts * x2) >> 30) / 272; tc = ((tc * x2) >> 30) / 240;
    s  = s + $signed(ts);         c  = c + $signed(tc);
    ts = ((ts * x2) >> 30) / 342; tc = ((tc * x2) >> 30) / 306;
    s  = s - $signed(ts);         c  = c - $signed(tc);
    ts = ((ts * x2) >> 30) / 420; tc = ((tc * x2) >> 30) / 380;
    s  = s + $signed(ts);         c  = c + $signed(tc);
    case (oct[2:0])
      3'd0: begin rc = c;  rs = s;  end
      3'd1: begin rc = s;  rs = c;  end
      3'd2: begin rc = -s; rs = c;  end
      3'd3: begin rc = -c; rs = s;  end
      3'd4: begin rc = -c; rs = -s; end
      3'd5: begin rc = -s; rs = -c; end
      3'd6: begin rc = s;  rs = -c; end
      default: begin rc = c; rs = -s; end
    endcase
    return {to_q16(rc), to_q16(rs)};
  endfunction

  function automatic twid_tab_t gen_table();
    twid_tab_t t;
    for (int k = 0; k < BINS; k++) begin
      t[k] = twiddle(k);
    end
    return t;
  endfunction

  localparam twid_tab_t TWID = gen_table();

  logic [35:0] tw_q;

  always_ff @(posedge clk_i) begin
    tw_q <= TWID[addr_i];
  end

  assign cos_o = tw_q[35:18];
  assign sin_o = tw_q[17:0];

endmodule

/* sv/sdft_mac.sv */
// Shared 25x25 multiplier with product register and accumulators.
// Depends on sdft_pkg (mac_ctrl_t, mac_op_e, widths).
module sdft_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sdft_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [sdft_pkg::SAMPLE_W-1:0] smp_i,
  input  logic signed [sdft_pkg::PR_W-1:0]     pr_i,
  input  logic signed [sdft_pkg::STATE_W-1:0]  pi_i,
  input  logic signed [sdft_pkg::TW_W-1:0]     cos_i,
  input  logic signed [sdft_pkg::TW_W-1:0]     sin_i,
  input  logic signed [sdft_pkg::INT_W-1:0]    ir_i,
  input  logic signed [sdft_pkg::INT_W-1:0]    ii_i,
  output logic signed [sdft_pkg::ACC_W-1:0]    acc_re_o,
  output logic signed [sdft_pkg::ACC_W-1:0]    acc_im_o,
  output logic [sdft_pkg::POW_W-1:0]           pow_o
);
  import sdft_pkg::*;

  logic signed [MUL_W-1:0]  pr_lo, pr_hi, pi_lo, pi_hi, c_x, s_x, ir_x, ii_x;
  logic signed [MUL_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] prod_q;
  mac_op_e                  tag_q;
  logic                     pvalid_q;
  logic signed [ACC_W-1:0]  acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic [POW_W-1:0]         pow_q, pow_d;
  logic signed [ACC_W-1:0]  term, base, sum;
  logic                     is_hi, is_re, is_neg, is_pwr;

  // operands split at bit 24: low slice unsigned, high slice signed
  assign pr_lo = $signed({1'b0, pr_i[SPLIT_W-1:0]});
  assign pr_hi = MUL_W'($signed(pr_i[PR_W-1:SPLIT_W]));
  assign pi_lo = $signed({1'b0, pi_i[SPLIT_W-1:0]});
  assign pi_hi = MUL_W'($signed(pi_i[STATE_W-1:SPLIT_W]));
  assign c_x   = MUL_W'(cos_i);
  assign s_x   = MUL_W'(sin_i);
  assign ir_x  = MUL_W'(ir_i);
  assign ii_x  = MUL_W'(ii_i);

  always_comb begin
    case (ctrl_i.op)
      MAC_RE_LO_C: begin op_a = pr_lo; op_b = c_x;  end
      MAC_RE_HI_C: begin op_a = pr_hi; op_b = c_x;  end
      MAC_RE_LO_S: begin op_a = pi_lo; op_b = s_x;  end
      MAC_RE_HI_S: begin op_a = pi_hi; op_b = s_x;  end
      MAC_IM_LO_S: begin op_a = pr_lo; op_b = s_x;  end
      MAC_IM_HI_S: begin op_a = pr_hi; op_b = s_x;  end
      MAC_IM_LO_C: begin op_a = pi_lo; op_b = c_x;  end
      MAC_IM_HI_C: begin op_a = pi_hi; op_b = c_x;  end
      MAC_PWR_RE:  begin op_a = ir_x;  op_b = ir_x; end
      MAC_PWR_IM:  begin op_a = ii_x;  op_b = ii_x; end
      default:     begin op_a = '0;    op_b = '0;   end
    endcase
  end

  always_comb begin
    is_hi  = 1'b0;
    is_re  = 1'b0;
    is_neg = 1'b0;
    is_pwr = 1'b0;
    case (tag_q)
      MAC_RE_LO_C: is_re = 1'b1;
      MAC_RE_HI_C: begin is_re = 1'b1; is_hi = 1'b1; end
      MAC_RE_LO_S: begin is_re = 1'b1; is_neg = 1'b1; end
      MAC_RE_HI_S: begin is_re = 1'b1; is_neg = 1'b1; is_hi = 1'b1; end
      MAC_IM_LO_S: ;
      MAC_IM_HI_S: is_hi = 1'b1;
      MAC_IM_LO_C: ;
      MAC_IM_HI_C: is_hi = 1'b1;
      MAC_PWR_RE:  is_pwr = 1'b1;
      MAC_PWR_IM:  is_pwr = 1'b1;
      default:     is_pwr = 1'b1;
    endcase

    term = ACC_W'(prod_q);
    if (is_hi) begin
      term = term <<< SPLIT_W;
    end
    if (is_neg) begin
      term = -term;
    end
    base = is_re ? acc_re_q : acc_im_q;
    sum  = base + term;

    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    pow_d    = pow_q;
    if (ctrl_i.init) begin
      // sample * 2^32 folds the sample add into the rounded sum
      acc_re_d = {{(ACC_W - SAMPLE_W - 32){smp_i[SAMPLE_W-1]}}, smp_i, 32'h0000_8000};
      acc_im_d = ACC_W'(32'h0000_8000);
    end else if (pvalid_q) begin
      if (is_pwr) begin
        pow_d = (tag_q == MAC_PWR_IM) ? pow_q + prod_q[POW_W-1:0] : prod_q[POW_W-1:0];
      end else if (is_re) begin
        acc_re_d = sum;
      end else begin
        acc_im_d = sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= 1'b0;
    end else begin
      pvalid_q <= ctrl_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      prod_q <= op_a * op_b;
      tag_q  <= ctrl_i.op;
    end
    acc_re_q <= acc_re_d;
    acc_im_q <= acc_im_d;
    pow_q    <= pow_d;
  end

  assign acc_re_o = acc_re_q;
  assign acc_im_o = acc_im_q;
  assign pow_o    = pow_q;

endmodule

/* sv/sliding_dft_dominant_bin_unit.sv */
// Sliding DFT over BINS bins with dominant-bin report; top level and sequencer.
// Depends on sdft_pkg, sdft_twiddle_rom and sdft_mac.
//
//   channel  | signals                              | dir | handshake
//   ---------+--------------------------------------+-----+------------------------
//   sample   | sample_i                             | in  | sample_valid_i / _stall_o
//   result   | dominant_bin_o, dominant_power_o     | out | result_valid_o / _stall_i
//
// Steps: one sample transaction walks every bin in turn. Each bin runs 16
//   steps on the shared 25x25 multiplier: memory read, operand prep, eight
//   partial products of the complex rotation, accumulate, round/saturate and
//   write back, two squares for the power, sum and compare.
// Reset: a clearing pass writes zeros to the sample ring and the bin memories,
//   one entry per cycle over all BINS entries; sample_stall_o is high meanwhile.
// Stalls: the result sits in an output register; a new sample is taken while
//   it waits. A finished result waits in the last step until that register frees.
module sliding_dft_dominant_bin_unit #(
  parameter int BINS = sdft_pkg::DEFAULT_BINS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 sample_valid_i,
  output logic                                 sample_stall_o,
  input  logic signed [sdft_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                 result_valid_o,
  input  logic                                 result_stall_i,
  output logic [sdft_pkg::BIN_W-1:0]           dominant_bin_o,
  output logic [sdft_pkg::POW_W-1:0]           dominant_power_o
);
  import sdft_pkg::*;

  localparam int AW   = $clog2(BINS);
  localparam int SH_W = ACC_W - FRAC_W;
  localparam logic [AW-1:0] LAST = AW'(BINS - 1);
  localparam logic signed [SH_W-1:0] SAT_HI = SH_W'((64'sd1 <<< (STATE_W - 1)) - 64'sd1);
  localparam logic signed [SH_W-1:0] SAT_LO = -SAT_HI - SH_W'(1);

  // sequencer state
  state_e            state_q, state_d;
  logic [AW-1:0]     k_q, k_d;          // bin index, also the clear-pass address
  logic [AW-1:0]     pos_q, pos_d;      // oldest ring slot
  logic [2:0]        cnt_q, cnt_d;      // step within multiply / power phases
  logic [AW-1:0]     best_idx_q, best_idx_d;
  logic [POW_W-1:0]  best_pow_q, best_pow_d;
  logic              out_valid_q, out_valid_d;

  // payload
  logic signed [SAMPLE_W-1:0] smp_q, smp_d;
  logic signed [PR_W-1:0]     pr_q, pr_d;
  logic signed [STATE_W-1:0]  pi_q, pi_d;
  logic signed [INT_W-1:0]    ir_q, ir_d, ii_q, ii_d;
  logic [BIN_W-1:0]           out_bin_q, out_bin_d;
  logic [POW_W-1:0]           out_pow_q, out_pow_d;

  // memories
  logic signed [SAMPLE_W-1:0] ring_mem [BINS];
  logic signed [STATE_W-1:0]  re_mem   [BINS];
  logic signed [STATE_W-1:0]  im_mem   [BINS];
  logic signed [SAMPLE_W-1:0] ring_rd_q;
  logic signed [STATE_W-1:0]  re_rd_q, im_rd_q;
  logic                       ring_we, ring_re, bin_we;
  logic [AW-1:0]              ring_addr;
  logic signed [SAMPLE_W-1:0] ring_wdata;
  logic signed [STATE_W-1:0]  re_wdata, im_wdata;

  // shared unit
  mac_ctrl_t                  mac_ctrl;
  logic signed [TW_W-1:0]     tw_cos, tw_sin;
  logic signed [ACC_W-1:0]    acc_re, acc_im;
  logic [POW_W-1:0]           pow;
  logic signed [SH_W-1:0]     re_sh, im_sh;
  logic signed [STATE_W-1:0]  re_sat, im_sat;
  logic                       in_accept, out_free;

  sdft_twiddle_rom #(
    .BINS (BINS)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (k_q),
    .cos_o  (tw_cos),
    .sin_o  (tw_sin)
  );

  sdft_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .smp_i    (smp_q),
    .pr_i     (pr_q),
    .pi_i     (pi_q),
    .cos_i    (tw_cos),
    .sin_i    (tw_sin),
    .ir_i     (ir_q),
    .ii_i     (ii_q),
    .acc_re_o (acc_re),
    .acc_im_o (acc_im),
    .pow_o    (pow)
  );

  assign sample_stall_o = (state_q != ST_IDLE);
  assign in_accept      = sample_valid_i && !sample_stall_o;
  assign out_free       = !out_valid_q || !result_stall_i;

  // accumulators already hold the rounding offset: drop the fraction and clamp
  assign re_sh  = acc_re[ACC_W-1:FRAC_W];
  assign im_sh  = acc_im[ACC_W-1:FRAC_W];
  assign re_sat = (re_sh > SAT_HI) ? STATE_W'(SAT_HI) :
                  (re_sh < SAT_LO) ? STATE_W'(SAT_LO) : STATE_W'(re_sh);
  assign im_sat = (im_sh > SAT_HI) ? STATE_W'(SAT_HI) :
                  (im_sh < SAT_LO) ? STATE_W'(SAT_LO) : STATE_W'(im_sh);

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    best_idx_d  = best_idx_q;
    best_pow_d  = best_pow_q;
    out_valid_d = out_valid_q;
    smp_d       = smp_q;
    pr_d        = pr_q;
    pi_d        = pi_q;
    ir_d        = ir_q;
    ii_d        = ii_q;
    out_bin_d   = out_bin_q;
    out_pow_d   = out_pow_q;

    ring_we     = 1'b0;
    ring_re     = 1'b0;
    ring_addr   = pos_q;
    ring_wdata  = sample_i;
    bin_we      = 1'b0;
    re_wdata    = re_sat;
    im_wdata    = im_sat;

    mac_ctrl.init  = 1'b0;
    mac_ctrl.issue = 1'b0;
    mac_ctrl.op    = MAC_RE_LO_C;

    if (out_valid_q && !result_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        ring_we    = 1'b1;
        ring_addr  = k_q;
        ring_wdata = '0;
        bin_we     = 1'b1;
        re_wdata   = '0;
        im_wdata   = '0;
        if (k_q == LAST) begin
          k_d     = '0;
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          // read the oldest sample and overwrite its slot in one access
          ring_we    = 1'b1;
          ring_re    = 1'b1;
          smp_d      = sample_i;
          pos_d      = (pos_q == LAST) ? '0 : pos_q + AW'(1);
          k_d        = '0;
          best_idx_d = '0;
          best_pow_d = '0;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_PREP;
      end
      ST_PREP: begin
        pr_d = PR_W'(re_rd_q) -
               {{(PR_W - SAMPLE_W - FRAC_W){ring_rd_q[SAMPLE_W-1]}}, ring_rd_q,
                {FRAC_W{1'b0}}};
        pi_d          = im_rd_q;
        mac_ctrl.init = 1'b1;
        cnt_d         = '0;
        state_d       = ST_MUL;
      end
      ST_MUL: begin
        mac_ctrl.issue = 1'b1;
        mac_ctrl.op    = mac_op_e'({1'b0, cnt_q});
        cnt_d          = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        state_d = ST_RND;
      end
      ST_RND: begin
        bin_we  = 1'b1;
        ir_d    = re_sat[STATE_W-1:FRAC_W];
        ii_d    = im_sat[STATE_W-1:FRAC_W];
        cnt_d   = '0;
        state_d = ST_PWR;
      end
      ST_PWR: begin
        mac_ctrl.issue = 1'b1;
        mac_ctrl.op    = cnt_q[0] ? MAC_PWR_IM : MAC_PWR_RE;
        cnt_d          = cnt_q + 3'd1;
        if (cnt_q[0]) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        // strict compare keeps the lowest index on ties
        if (pow > best_pow_q) begin
          best_pow_d = pow;
          best_idx_d = k_q;
        end
        if (k_q == LAST) begin
          state_d = ST_DONE;
        end else begin
          k_d     = k_q + AW'(1);
          state_d = ST_READ;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_bin_d   = BIN_W'(best_idx_q);
          out_pow_d   = best_pow_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      k_q         <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      best_idx_q  <= '0;
      best_pow_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      best_idx_q  <= best_idx_d;
      best_pow_q  <= best_pow_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q     <= smp_d;
    pr_q      <= pr_d;
    pi_q      <= pi_d;
    ir_q      <= ir_d;
    ii_q      <= ii_d;
    out_bin_q <= out_bin_d;
    out_pow_q <= out_pow_d;
  end

  // sample ring: read-before-write at the oldest slot
  always_ff @(posedge clk_i) begin
    if (ring_re) begin
      ring_rd_q <= ring_mem[ring_addr];
    end
    if (ring_we) begin
      ring_mem[ring_addr] <= ring_wdata;
    end
  end

  // bin state, read and written at the current bin index
  always_ff @(posedge clk_i) begin
    re_rd_q <= re_mem[k_q];
    im_rd_q <= im_mem[k_q];
    if (bin_we) begin
      re_mem[k_q] <= re_wdata;
      im_mem[k_q] <= im_wdata;
    end
  end

  assign result_valid_o   = out_valid_q;
  assign dominant_bin_o   = out_bin_q;
  assign dominant_power_o = out_pow_q;

endmodule
